[design/mctf_pkg.sv]
`timescale 1ns / 1ps

package mctf_pkg;

    // Block constants.
    localparam int TICKS_PER_QUARTER = 24;
    localparam int MAX_CATCH_UP      = 32;

    localparam int US_PER_MINUTE = 60000000;
    localparam int SLOW_BPM      = 20;
    localparam int FAST_BPM      = 300;
    localparam int START_BPM     = 120;
    localparam int SILENCE_US    = 500000;

    localparam int PERIOD_W       = 17;
    localparam int PERIOD_MAX_INT = (1 << PERIOD_W) - 1;
    localparam logic [PERIOD_W-1:0] PERIOD_MAX = PERIOD_W'(PERIOD_MAX_INT);

    localparam int RAW_START_PERIOD = US_PER_MINUTE / START_BPM / TICKS_PER_QUARTER;
    localparam logic [PERIOD_W-1:0] START_PERIOD =
        (RAW_START_PERIOD > PERIOD_MAX_INT) ? PERIOD_MAX :
        (RAW_START_PERIOD == 0) ? PERIOD_W'(1) : PERIOD_W'(RAW_START_PERIOD);

    localparam logic [31:0] QUARTER_MIN_US = 32'(US_PER_MINUTE / FAST_BPM);
    localparam logic [31:0] QUARTER_MAX_US = 32'(US_PER_MINUTE / SLOW_BPM);
    localparam logic [31:0] SILENCE_LIMIT  = 32'(SILENCE_US);

    // Reciprocal multiply for the quarter length divided by the pulses per quarter.
    // It is exact for every interval below 2^QUARTER_X_W, which covers the longest
    // accepted quarter.
    localparam int QUARTER_X_W       = 22;
    localparam int QUARTER_SHIFT     = 29;
    localparam int RECIP_W           = QUARTER_SHIFT + 1;
    localparam int QUARTER_RECIP_INT =
        ((1 << QUARTER_SHIFT) + TICKS_PER_QUARTER - 1) / TICKS_PER_QUARTER;
    localparam logic [RECIP_W-1:0] QUARTER_RECIP = RECIP_W'(QUARTER_RECIP_INT);
    localparam int QPROD_W = QUARTER_X_W + RECIP_W;
    localparam int QLEN_W  = QPROD_W - QUARTER_SHIFT;

    localparam int TPD_W = 9;
    localparam logic [TPD_W-1:0] TPD_RESET = TPD_W'(24);

    localparam int TIQ_W = (TICKS_PER_QUARTER > 1) ? $clog2(TICKS_PER_QUARTER) : 1;

    localparam int TIME_W   = 32;
    localparam int POS_W    = 40;
    localparam int FRAC_W   = 9;
    localparam int DIV_STEPS = 32;

    // Command codes carried by an input transaction.
    typedef enum logic [2:0] {
        CMD_POLL     = 3'd0,
        CMD_CLOCK    = 3'd1,
        CMD_START    = 3'd2,
        CMD_CONTINUE = 3'd3,
        CMD_STOP     = 3'd4,
        CMD_BEGIN    = 3'd5
    } cmd_t;

    typedef struct packed {
        logic [2:0]        cmd;
        logic [TIME_W-1:0] now_us;
    } in_t;

    typedef struct packed {
        logic [POS_W-1:0]    position_ticks;
        logic                beat_started;
        logic                running;
        logic [PERIOD_W-1:0] tick_period_us;
    } out_t;

    // Datapath micro-operations.
    typedef enum logic [4:0] {
        OP_NOP,
        OP_CLR_BEAT,
        OP_CATCH_UP,
        OP_DIV_ELAPSED,
        OP_FR_APPLY,
        OP_DIV_FRAC,
        OP_FRAC_TAKE,
        OP_FRAC_SAT,
        OP_POS,
        OP_DIV_BEAT,
        OP_BEAT,
        OP_LBI,
        OP_CLOCK,
        OP_PERIOD,
        OP_LQT,
        OP_START,
        OP_CONT,
        OP_STOP,
        OP_BEGIN,
        OP_EMIT
    } op_t;

    // Jump conditions.
    typedef enum logic [3:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_STOPPED,
        COND_RECENT,
        COND_DIV_BUSY,
        COND_DIFF_GE_PER,
        COND_TIQ_NZ,
        COND_NO_MEASURE,
        COND_EMIT_BLOCK
    } cond_t;

    typedef enum logic {
        SEQ_IDLE,
        SEQ_RUN
    } seq_state_t;

    localparam int PC_W = 5;

    // Program entry points and jump targets.
    localparam int A_POLL      = 0;
    localparam int A_POLL_SKIP = 6;
    localparam int A_POLL_SAT  = 10;
    localparam int A_POLL_POS  = 11;
    localparam int A_EMIT      = 15;
    localparam int A_CLOCK     = 16;
    localparam int A_CLOCK_LQT = 20;
    localparam int A_START     = 21;
    localparam int A_CONT      = 22;
    localparam int A_STOP      = 23;
    localparam int A_BEGIN     = 24;
    localparam int A_CFG       = 25;

    typedef struct packed {
        op_t             op;
        cond_t           cond;
        logic [PC_W-1:0] target;
        logic            done;
    } ctrl_t;

    typedef struct packed {
        logic stopped;
        logic recent;
        logic div_busy;
        logic diff_ge_per;
        logic tiq_nz;
        logic no_measure;
        logic emit_block;
    } stat_t;

    typedef struct packed {
        logic                start;
        logic [TIME_W-1:0]   dividend;
        logic [PERIOD_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic                busy;
        logic [TIME_W-1:0]   quotient;
        logic [PERIOD_W-1:0] remainder;
    } div_rsp_t;

    function automatic ctrl_t cw(input op_t op, input cond_t cond, input int target,
                                 input logic done);
        ctrl_t w;
        w.op     = op;
        w.cond   = cond;
        w.target = PC_W'(target);
        w.done   = done;
        return w;
    endfunction

    // Control store: one control word per program step.
    function automatic ctrl_t ucode(input logic [PC_W-1:0] addr);
        ctrl_t w;
        case (addr)
            // Poll program.
            PC_W'(0):  w = cw(OP_CLR_BEAT,    COND_STOPPED,     A_EMIT,      1'b0);
            PC_W'(1):  w = cw(OP_NOP,         COND_RECENT,      A_POLL_SKIP, 1'b0);
            PC_W'(2):  w = cw(OP_CATCH_UP,    COND_NEVER,       0,           1'b0);
            PC_W'(3):  w = cw(OP_DIV_ELAPSED, COND_NEVER,       0,           1'b0);
            PC_W'(4):  w = cw(OP_NOP,         COND_DIV_BUSY,    4,           1'b0);
            PC_W'(5):  w = cw(OP_FR_APPLY,    COND_NEVER,       0,           1'b0);
            PC_W'(6):  w = cw(OP_NOP,         COND_DIFF_GE_PER, A_POLL_SAT,  1'b0);
            PC_W'(7):  w = cw(OP_DIV_FRAC,    COND_NEVER,       0,           1'b0);
            PC_W'(8):  w = cw(OP_NOP,         COND_DIV_BUSY,    8,           1'b0);
            PC_W'(9):  w = cw(OP_FRAC_TAKE,   COND_ALWAYS,      A_POLL_POS,  1'b0);
            PC_W'(10): w = cw(OP_FRAC_SAT,    COND_NEVER,       0,           1'b0);
            PC_W'(11): w = cw(OP_POS,         COND_NEVER,       0,           1'b0);
            PC_W'(12): w = cw(OP_DIV_BEAT,    COND_NEVER,       0,           1'b0);
            PC_W'(13): w = cw(OP_NOP,         COND_DIV_BUSY,    13,          1'b0);
            PC_W'(14): w = cw(OP_BEAT,        COND_NEVER,       0,           1'b0);
            // Shared result step.
            PC_W'(15): w = cw(OP_EMIT,        COND_EMIT_BLOCK,  A_EMIT,      1'b1);
            // Clock pulse program.
            PC_W'(16): w = cw(OP_CLOCK,       COND_NEVER,       0,           1'b0);
            PC_W'(17): w = cw(OP_NOP,         COND_TIQ_NZ,      A_EMIT,      1'b0);
            PC_W'(18): w = cw(OP_NOP,         COND_NO_MEASURE,  A_CLOCK_LQT, 1'b0);
            PC_W'(19): w = cw(OP_PERIOD,      COND_NEVER,       0,           1'b0);
            PC_W'(20): w = cw(OP_LQT,         COND_ALWAYS,      A_EMIT,      1'b0);
            // Transport commands.
            PC_W'(21): w = cw(OP_START,       COND_ALWAYS,      A_EMIT,      1'b0);
            PC_W'(22): w = cw(OP_CONT,        COND_ALWAYS,      A_EMIT,      1'b0);
            PC_W'(23): w = cw(OP_STOP,        COND_ALWAYS,      A_EMIT,      1'b0);
            PC_W'(24): w = cw(OP_BEGIN,       COND_ALWAYS,      A_EMIT,      1'b0);
            // Division register write: recompute the last beat index.
            PC_W'(25): w = cw(OP_DIV_BEAT,    COND_NEVER,       0,           1'b0);
            PC_W'(26): w = cw(OP_NOP,         COND_DIV_BUSY,    26,          1'b0);
            PC_W'(27): w = cw(OP_LBI,         COND_NEVER,       0,           1'b1);
            default:   w = cw(OP_NOP,         COND_NEVER,       0,           1'b1);
        endcase
        return w;
    endfunction

    // Program entry for each command; unused codes only emit a result.
    function automatic logic [PC_W-1:0] entry(input logic [2:0] cmd);
        logic [PC_W-1:0] a;
        case (cmd)
            CMD_POLL:     a = PC_W'(A_POLL);
            CMD_CLOCK:    a = PC_W'(A_CLOCK);
            CMD_START:    a = PC_W'(A_START);
            CMD_CONTINUE: a = PC_W'(A_CONT);
            CMD_STOP:     a = PC_W'(A_STOP);
            CMD_BEGIN:    a = PC_W'(A_BEGIN);
            default:      a = PC_W'(A_EMIT);
        endcase
        return a;
    endfunction

endpackage

[design/mctf_divider.sv]
`timescale 1ns / 1ps

module mctf_divider (
    input  logic                clk,
    input  logic                rst_n,
    input  mctf_pkg::div_req_t  req,
    output mctf_pkg::div_rsp_t  rsp
);
    import mctf_pkg::*;

    localparam int CNT_W = $clog2(DIV_STEPS + 1);

    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [TIME_W-1:0]   quot_reg, quot_next;
    logic [PERIOD_W-1:0] rem_reg, rem_next;
    logic [PERIOD_W-1:0] den_reg, den_next;

    logic [PERIOD_W:0]   trial;
    logic [PERIOD_W:0]   trial_diff;
    logic                take;

    // One restoring step: shift in the next dividend bit and try the subtract.
    always_comb
    begin
        trial      = {rem_reg, quot_reg[TIME_W-1]};
        trial_diff = trial - {1'b0, den_reg};
        take       = (trial >= {1'b0, den_reg});
    end

    always_comb
    begin
        cnt_next  = cnt_reg;
        quot_next = quot_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (req.start)
        begin
            cnt_next  = CNT_W'(DIV_STEPS);
            quot_next = req.dividend;
            rem_next  = '0;
            den_next  = req.divisor;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next  = cnt_reg - CNT_W'(1);
            quot_next = {quot_reg[TIME_W-2:0], take};
            rem_next  = take ? trial_diff[PERIOD_W-1:0] : trial[PERIOD_W-1:0];
        end
    end

    // Step counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    // Working registers.
    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
    end

    assign rsp.busy      = (cnt_reg != '0);
    assign rsp.quotient  = quot_reg;
    assign rsp.remainder = rem_reg;

    // The program must never start a division while one is in progress.
    assert property (@(posedge clk) disable iff (!rst_n) req.start |-> !rsp.busy)
        else $error("divider started while busy");

endmodule

[design/mctf_sequencer.sv]
`timescale 1ns / 1ps

module mctf_sequencer (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_accept,
    input  logic [2:0]        in_cmd,
    input  logic              cfg_accept,
    input  mctf_pkg::stat_t   stat,
    output mctf_pkg::ctrl_t   ctrl,
    output logic              idle
);
    import mctf_pkg::*;

    seq_state_t      state_reg, state_next;
    logic [PC_W-1:0] pc_reg, pc_next;
    ctrl_t           word;
    logic            jump;

    assign word = ucode(pc_reg);

    // Evaluate the jump condition of the current step.
    always_comb
    begin
        case (word.cond)
            COND_NEVER:       jump = 1'b0;
            COND_ALWAYS:      jump = 1'b1;
            COND_STOPPED:     jump = stat.stopped;
            COND_RECENT:      jump = stat.recent;
            COND_DIV_BUSY:    jump = stat.div_busy;
            COND_DIFF_GE_PER: jump = stat.diff_ge_per;
            COND_TIQ_NZ:      jump = stat.tiq_nz;
            COND_NO_MEASURE:  jump = stat.no_measure;
            COND_EMIT_BLOCK:  jump = stat.emit_block;
            default:          jump = 1'b0;
        endcase
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            SEQ_IDLE:
            begin
                if (cfg_accept || in_accept)
                begin
                    state_next = SEQ_RUN;
                end
            end
            SEQ_RUN:
            begin
                if (!jump && word.done)
                begin
                    state_next = SEQ_IDLE;
                end
            end
            default: state_next = SEQ_IDLE;
        endcase
    end

    // Step counter: dispatch on a transaction, then step or jump.
    always_comb
    begin
        pc_next = pc_reg;
        case (state_reg)
            SEQ_IDLE:
            begin
                if (cfg_accept)
                begin
                    pc_next = PC_W'(A_CFG);
                end
                else if (in_accept)
                begin
                    pc_next = entry(in_cmd);
                end
            end
            SEQ_RUN:
            begin
                if (jump)
                begin
                    pc_next = word.target;
                end
                else if (!word.done)
                begin
                    pc_next = pc_reg + PC_W'(1);
                end
            end
            default: pc_next = pc_reg;
        endcase
    end

    // Outputs.
    always_comb
    begin
        idle = (state_reg == SEQ_IDLE);
        if (state_reg == SEQ_RUN)
        begin
            ctrl = word;
        end
        else
        begin
            ctrl = cw(OP_NOP, COND_NEVER, 0, 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SEQ_IDLE;
            pc_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
        end
    end

endmodule

[design/mctf_datapath.sv]
`timescale 1ns / 1ps

module mctf_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_accept,
    input  mctf_pkg::in_t                 in_data,
    input  logic                          cfg_accept,
    input  logic [mctf_pkg::TPD_W-1:0]    cfg_data,
    input  mctf_pkg::ctrl_t               ctrl,
    input  mctf_pkg::div_rsp_t            div_rsp,
    input  logic                          out_ready,
    output mctf_pkg::div_req_t            div_req,
    output mctf_pkg::stat_t               stat,
    output logic                          out_valid,
    output mctf_pkg::out_t                out_data
);
    import mctf_pkg::*;

    // Follower state.
    logic [TIME_W-1:0]   tick_count_reg, tick_count_next;
    logic [TIME_W-1:0]   ltt_reg, ltt_next;
    logic [TIME_W-1:0]   lct_reg, lct_next;
    logic [PERIOD_W-1:0] period_reg, period_next;
    logic [TIQ_W-1:0]    tiq_reg, tiq_next;
    logic [TIME_W-1:0]   lqt_reg, lqt_next;
    logic [TIME_W-1:0]   lbi_reg, lbi_next;
    logic                beat_reg, beat_next;
    logic                run_reg, run_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [TPD_W-1:0]    tpd_reg, tpd_next;
    logic                out_valid_reg, out_valid_next;

    // Working and result payload.
    logic [TIME_W-1:0]   now_reg, now_next;
    logic [FRAC_W-1:0]   frac_reg, frac_next;
    out_t                out_data_reg, out_data_next;

    logic [TIME_W-1:0]   elapsed;
    logic [TIME_W-1:0]   since_clock;
    logic [TIME_W-1:0]   interval;
    logic [PERIOD_W-1:0] per_eff;
    logic [TIME_W-1:0]   catch_limit;
    logic [TPD_W-1:0]    div_eff;
    logic [TIQ_W:0]      tiq_inc;
    logic                tiq_wrap;
    logic                emit_ok;
    logic [QPROD_W-1:0]  quarter_prod;
    logic [QLEN_W-1:0]   quarter_len;
    logic [PERIOD_W-1:0] period_sat;

    // Time differences and derived values.
    always_comb
    begin
        elapsed     = now_reg - ltt_reg;
        since_clock = now_reg - lct_reg;
        interval    = now_reg - lqt_reg;
        per_eff     = (period_reg == '0) ? PERIOD_W'(1) : period_reg;
        catch_limit = {{(TIME_W-PERIOD_W){1'b0}}, per_eff} * TIME_W'(MAX_CATCH_UP);
        div_eff     = (tpd_reg == '0) ? TPD_W'(1) : tpd_reg;
        tiq_inc     = {1'b0, tiq_reg} + (TIQ_W+1)'(1);
        tiq_wrap    = (tiq_inc == (TIQ_W+1)'(TICKS_PER_QUARTER));
        emit_ok     = !(out_valid_reg && !out_ready);
        // Quarter length per pulse by reciprocal multiply; only used for accepted quarters.
        quarter_prod = {{RECIP_W{1'b0}}, interval[QUARTER_X_W-1:0]} *
                       {{QUARTER_X_W{1'b0}}, QUARTER_RECIP};
        quarter_len  = quarter_prod[QPROD_W-1:QUARTER_SHIFT];
        if (quarter_len > {{(QLEN_W-PERIOD_W){1'b0}}, PERIOD_MAX})
        begin
            period_sat = PERIOD_MAX;
        end
        else if (quarter_len == '0)
        begin
            period_sat = PERIOD_W'(1);
        end
        else
        begin
            period_sat = quarter_len[PERIOD_W-1:0];
        end
    end

    // Status flags for the sequencer.
    always_comb
    begin
        stat.stopped     = !run_reg;
        stat.recent      = (since_clock < SILENCE_LIMIT);
        stat.div_busy    = div_rsp.busy;
        stat.diff_ge_per = (elapsed >= {{(TIME_W-PERIOD_W){1'b0}}, period_reg});
        stat.tiq_nz      = (tiq_reg != '0);
        stat.no_measure  = (lqt_reg == '0) || (interval < QUARTER_MIN_US) ||
                           (interval > QUARTER_MAX_US);
        stat.emit_block  = !emit_ok;
    end

    // Divider operand selection.
    always_comb
    begin
        div_req.start    = 1'b0;
        div_req.dividend = '0;
        div_req.divisor  = PERIOD_W'(1);
        case (ctrl.op)
            OP_DIV_ELAPSED:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = elapsed;
                div_req.divisor  = per_eff;
            end
            OP_DIV_FRAC:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = {{(TIME_W-PERIOD_W-8){1'b0}}, elapsed[PERIOD_W-1:0], 8'h00};
                div_req.divisor  = period_reg;
            end
            OP_DIV_BEAT:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = tick_count_reg;
                div_req.divisor  = {{(PERIOD_W-TPD_W){1'b0}}, div_eff};
            end
            default:
            begin
                div_req.start = 1'b0;
            end
        endcase
    end

    // Micro-operation execution.
    always_comb
    begin
        tick_count_next = tick_count_reg;
        ltt_next        = ltt_reg;
        lct_next        = lct_reg;
        period_next     = period_reg;
        tiq_next        = tiq_reg;
        lqt_next        = lqt_reg;
        lbi_next        = lbi_reg;
        beat_next       = beat_reg;
        run_next        = run_reg;
        pos_next        = pos_reg;
        tpd_next        = tpd_reg;
        frac_next       = frac_reg;
        now_next        = now_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_data_next   = out_data_reg;

        if (in_accept)
        begin
            now_next = in_data.now_us;
        end
        if (cfg_accept)
        begin
            tpd_next = cfg_data;
        end

        case (ctrl.op)
            OP_CLR_BEAT:
            begin
                beat_next = 1'b0;
            end
            OP_CATCH_UP:
            begin
                if (elapsed > catch_limit)
                begin
                    ltt_next = now_reg - {{(TIME_W-PERIOD_W){1'b0}}, per_eff};
                end
            end
            OP_FR_APPLY:
            begin
                // Adding whole periods leaves the tick time one remainder behind now.
                tick_count_next = tick_count_reg + div_rsp.quotient;
                ltt_next        = now_reg - {{(TIME_W-PERIOD_W){1'b0}}, div_rsp.remainder};
            end
            OP_FRAC_TAKE:
            begin
                frac_next = div_rsp.quotient[FRAC_W-1:0];
            end
            OP_FRAC_SAT:
            begin
                frac_next = FRAC_W'(256);
            end
            OP_POS:
            begin
                pos_next = {tick_count_reg, 8'h00} + {{(POS_W-FRAC_W){1'b0}}, frac_reg};
            end
            OP_BEAT:
            begin
                beat_next = (div_rsp.quotient != lbi_reg);
                lbi_next  = div_rsp.quotient;
            end
            OP_LBI:
            begin
                lbi_next = div_rsp.quotient;
            end
            OP_CLOCK:
            begin
                lct_next = now_reg;
                tiq_next = tiq_wrap ? '0 : tiq_inc[TIQ_W-1:0];
                if (run_reg)
                begin
                    tick_count_next = tick_count_reg + TIME_W'(1);
                    ltt_next        = now_reg;
                end
            end
            OP_PERIOD:
            begin
                period_next = period_sat;
            end
            OP_LQT:
            begin
                lqt_next = now_reg;
            end
            OP_START:
            begin
                tick_count_next = '0;
                tiq_next        = '0;
                lqt_next        = '0;
                lbi_next        = '0;
                pos_next        = '0;
                ltt_next        = now_reg;
                lct_next        = now_reg;
                run_next        = 1'b1;
            end
            OP_CONT:
            begin
                ltt_next = now_reg;
                lct_next = now_reg;
                run_next = 1'b1;
            end
            OP_STOP:
            begin
                run_next = 1'b0;
            end
            OP_BEGIN:
            begin
                ltt_next = now_reg;
                lct_next = now_reg;
            end
            OP_EMIT:
            begin
                if (emit_ok)
                begin
                    out_valid_next               = 1'b1;
                    out_data_next.position_ticks = pos_reg;
                    out_data_next.beat_started   = beat_reg;
                    out_data_next.running        = run_reg;
                    out_data_next.tick_period_us = period_reg;
                end
            end
            default:
            begin
                frac_next = frac_reg;
            end
        endcase
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_count_reg <= '0;
            ltt_reg        <= '0;
            lct_reg        <= '0;
            period_reg     <= START_PERIOD;
            tiq_reg        <= '0;
            lqt_reg        <= '0;
            lbi_reg        <= '0;
            beat_reg       <= 1'b0;
            run_reg        <= 1'b1;
            pos_reg        <= '0;
            tpd_reg        <= TPD_RESET;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            tick_count_reg <= tick_count_next;
            ltt_reg        <= ltt_next;
            lct_reg        <= lct_next;
            period_reg     <= period_next;
            tiq_reg        <= tiq_next;
            lqt_reg        <= lqt_next;
            lbi_reg        <= lbi_next;
            beat_reg       <= beat_next;
            run_reg        <= run_next;
            pos_reg        <= pos_next;
            tpd_reg        <= tpd_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        now_reg      <= now_next;
        frac_reg     <= frac_next;
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // The measured period is never zero, so frac and free-run never divide by zero.
    assert property (@(posedge clk) disable iff (!rst_n) period_reg != '0)
        else $error("tick period reached zero");

    // The quarter counter wraps before reaching the pulses per quarter.
    assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, tiq_reg} < (TIQ_W+1)'(TICKS_PER_QUARTER))
        else $error("quarter tick counter out of range");

    // A result is loaded only when the output register is free or being drained.
    assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.op == OP_EMIT && out_valid_reg && !out_ready) |=> out_valid_reg &&
        $stable(out_data_reg))
        else $error("pending result overwritten");

endmodule

[design/midi_clock_tempo_follower.sv]
`timescale 1ns / 1ps

// Channel   Direction  Handshake              Payload
// in        input      in_valid / in_ready    in_data   (cmd, now_us)
// out       output     out_valid / out_ready  out_data  (position, beat, running, period)
// cfg       input      cfg_valid / cfg_ready  cfg_data  (ticks_per_division)
//
// A poll and a register write may wait on the 32-step iterative divider; a clock pulse
// and the other commands do not use it.
// The next transaction is accepted once the sequencer is idle again, even if the
// previous result is still waiting in the output register.
// A result that is not taken stalls the sequencer only at its final step.
// Reset is asynchronous and active low and needs no clearing pass.

module midi_clock_tempo_follower (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  mctf_pkg::in_t               in_data,
    output logic                        out_valid,
    input  logic                        out_ready,
    output mctf_pkg::out_t              out_data,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [mctf_pkg::TPD_W-1:0]  cfg_data
);
    import mctf_pkg::*;

    logic     idle;
    logic     in_accept;
    logic     cfg_accept;
    ctrl_t    ctrl;
    stat_t    stat;
    div_req_t div_req;
    div_rsp_t div_rsp;

    // Handshakes: a register write takes precedence over an input transaction.
    assign cfg_ready  = idle;
    assign in_ready   = idle && !cfg_valid;
    assign cfg_accept = cfg_valid && cfg_ready;
    assign in_accept  = in_valid && in_ready;

    mctf_sequencer u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_accept  (in_accept),
        .in_cmd     (in_data.cmd),
        .cfg_accept (cfg_accept),
        .stat       (stat),
        .ctrl       (ctrl),
        .idle       (idle)
    );

    mctf_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_accept  (in_accept),
        .in_data    (in_data),
        .cfg_accept (cfg_accept),
        .cfg_data   (cfg_data),
        .ctrl       (ctrl),
        .div_rsp    (div_rsp),
        .out_ready  (out_ready),
        .div_req    (div_req),
        .stat       (stat),
        .out_valid  (out_valid),
        .out_data   (out_data)
    );

    mctf_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // An accepted transaction always leaves the sequencer busy in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept || cfg_accept) |=> !in_ready && !cfg_ready)
        else $error("sequencer did not start on an accepted transaction");

endmodule
